// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCBA_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcba assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcba assertion failed");

`endif

// File: hw/rtl/bcba_pkg.sv
// Types and constants of the bitmap contiguous block allocator.
package bcba_pkg;

	localparam int BLK_TOTAL_DEF = 512;
	localparam int SEG_W         = 8;

	localparam int FUNC_W    = 2;
	localparam int START_W   = 9;
	localparam int CNT_W     = 10;
	localparam int STAT_W    = 2;
	localparam int IDX_OUT_W = 9;
	localparam int FREE_W    = 10;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC_RUN = 2'd0,
		FN_FREE      = 2'd1,
		FN_MARK      = 2'd2,
		FN_ALLOC_ONE = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_BAD     = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_DONE
	} bcba_state_t;

endpackage

// File: hw/rtl/bcba_req_if.sv
// Request channel: function, start block and block count.
interface bcba_req_if import bcba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [START_W-1:0] start_req;
	logic [CNT_W-1:0]   count;

	modport source (output valid, output func, output start_req, output count, input ready);
	modport sink (input valid, input func, input start_req, input count, output ready);
endinterface

// File: hw/rtl/bcba_rsp_if.sv
// Response channel: status, first block and remaining free count.
interface bcba_rsp_if import bcba_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STAT_W-1:0]    status;
	logic [IDX_OUT_W-1:0] first_blk;
	logic [FREE_W-1:0]    free_count;

	modport source (output valid, output status, output first_blk, output free_count,
		input ready);
	modport sink (input valid, input status, input first_blk, input free_count,
		output ready);
endinterface

// File: hw/rtl/bitmap_contiguous_block_allocator.sv
// Bitmap first-fit block allocator: one used bit per block, free count, one response per request.
//
// Requests arrive on req (func, start_req, count) and each gives exactly one response on rsp
// (status, first_blk, free_count). A transfer happens when valid and ready are both high.
// The used bitmap sits in a memory of SEG_W-bit segments; one shared segment unit walks it,
// one segment per cycle, to scan for a run to allocate and to read-modify-write the range.
// Steps from request transfer to response valid, with the output register free:
//   bad range or count          : straight to the response
//   free / mark one             : an update pass over the segments spanned
//   allocate run / allocate one : a scan until the run is found, then an update pass
//   no space found              : a scan over all segments
// With 512 blocks a full scan is 64 segments.
// req.ready is high only while the sequencer is idle; one request is worked on at a time.
// A finished response waits in an output register, so the next request is taken while the
// receiver stalls; a second finished response waits until the first has been transferred.
// After reset a clearing pass writes all NUM_SEGS segments (64 with 512 blocks) of the bitmap,
// marking block 0 used; no request is taken during it. The free count resets to BLK_TOTAL-1.
module bitmap_contiguous_block_allocator import bcba_pkg::*; #(
	parameter int BLK_TOTAL = BLK_TOTAL_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bcba_req_if.sink   req,
	bcba_rsp_if.source rsp
);

	localparam int NUM_SEGS = (BLK_TOTAL + SEG_W - 1) / SEG_W;
	localparam int SEG_AW   = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
	localparam int BIT_AW   = $clog2(SEG_W);
	localparam int BIDX_W   = SEG_AW + BIT_AW;
	localparam int ISS_W    = SEG_AW + 1;
	localparam int PC_W     = BIT_AW + 1;
	localparam int FT_W     = $clog2(BLK_TOTAL + 1);
	localparam int SUM_W    = (FT_W > START_W + 2) ? FT_W : START_W + 2;
	localparam int BX_W     = (BIDX_W > IDX_OUT_W) ? BIDX_W : IDX_OUT_W;
	localparam int FX_W     = (FT_W > FREE_W) ? FT_W : FREE_W;

	bcba_state_t state_q, state_d;

	logic [SEG_W-1:0] map_mem [NUM_SEGS];
	logic [SEG_W-1:0] rdata_s1;
	logic [SEG_AW-1:0] seg_s1;
	logic dv_s1;

	logic [ISS_W-1:0]  iss_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  run_q;
	logic [BIDX_W-1:0] lo_q;
	logic [BIDX_W-1:0] hi_q;
	logic              set_q;
	stat_t             res_stat_q;
	logic [BIDX_W-1:0] res_idx_q;
	logic [FT_W-1:0]   free_q;

	logic                 out_valid_q;
	logic [STAT_W-1:0]    out_stat_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [FREE_W-1:0]    out_free_q;

	logic req_xfer, out_free, load_out;
	logic rd_en, we;
	logic [SEG_AW-1:0] rd_addr, waddr;
	logic [SEG_W-1:0]  wdata;

	func_t             fn;
	logic [CNT_W-1:0]  cnt_eff;
	logic [SUM_W-1:0]  start_x, range_end_x, range_last_x;
	logic              req_bad;
	logic [BIDX_W-1:0] req_lo, req_hi;

	logic [SEG_W-1:0]  pad, in_rng, new_seg, flip;
	logic [CNT_W-1:0]  run;
	logic              hit;
	logic [BIT_AW-1:0] hit_bit;
	logic [BIDX_W-1:0] scan_end, scan_first;
	logic [SUM_W-1:0]  first_x;
	logic              scan_hit, scan_last, upd_last;
	logic [PC_W-1:0]   pc;
	logic [SEG_AW-1:0] hi_seg;
	logic [BX_W-1:0]   idx_x;
	logic [FX_W-1:0]   free_x;

	// request decode
	assign fn           = func_t'(req.func);
	assign cnt_eff      = (fn == FN_ALLOC_ONE) ? CNT_W'(1) : req.count;
	assign start_x      = SUM_W'(req.start_req);
	assign range_end_x  = start_x + SUM_W'(req.count);
	assign range_last_x = range_end_x - SUM_W'(1);
	assign req_lo       = start_x[BIDX_W-1:0];
	assign req_hi       = (fn == FN_FREE) ? range_last_x[BIDX_W-1:0] : start_x[BIDX_W-1:0];

	always_comb begin
		unique case (fn)
			FN_ALLOC_RUN: req_bad = (req.count == '0);
			FN_FREE:      req_bad = (req.count == '0) || (range_end_x > SUM_W'(BLK_TOTAL));
			FN_MARK:      req_bad = (start_x >= SUM_W'(BLK_TOTAL));
			FN_ALLOC_ONE: req_bad = 1'b0;
			default:      req_bad = 1'b0;
		endcase
	end

	// segment unit: run scan and range update over one segment
	always_comb begin
		for (int k = 0; k < SEG_W; k++) begin
			pad[k]    = SUM_W'({seg_s1, BIT_AW'(k)}) >= SUM_W'(BLK_TOTAL);
			in_rng[k] = ({seg_s1, BIT_AW'(k)} >= lo_q) && ({seg_s1, BIT_AW'(k)} <= hi_q);
		end
	end

	always_comb begin
		run     = run_q;
		hit     = 1'b0;
		hit_bit = '0;
		for (int k = 0; k < SEG_W; k++) begin
			if (rdata_s1[k] || pad[k]) begin
				run = '0;
			end else begin
				run = run + CNT_W'(1);
			end
			if (!hit && run == cnt_q) begin
				hit     = 1'b1;
				hit_bit = BIT_AW'(k);
			end
		end
	end

	assign scan_end   = {seg_s1, hit_bit};
	assign first_x    = SUM_W'(scan_end) + SUM_W'(1) - SUM_W'(cnt_q);
	assign scan_first = first_x[BIDX_W-1:0];
	assign scan_hit   = dv_s1 && hit;
	assign scan_last  = dv_s1 && (seg_s1 == SEG_AW'(NUM_SEGS - 1));

	assign new_seg = set_q ? (rdata_s1 | in_rng) : (rdata_s1 & ~in_rng);
	assign flip    = set_q ? (in_rng & ~rdata_s1) : (in_rng & rdata_s1);
	assign hi_seg  = hi_q[BIDX_W-1 -: SEG_AW];
	assign upd_last = dv_s1 && (seg_s1 == hi_seg);

	always_comb begin
		pc = '0;
		for (int k = 0; k < SEG_W; k++) begin
			pc = pc + PC_W'(flip[k]);
		end
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign req_xfer = req.valid && req.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (iss_q == ISS_W'(NUM_SEGS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_xfer) begin
					if (req_bad) begin
						state_d = S_DONE;
					end else if (fn == FN_FREE || fn == FN_MARK) begin
						state_d = S_UPDATE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					state_d = S_UPDATE;
				end else if (scan_last) begin
					state_d = S_DONE;
				end
			end
			S_UPDATE: begin
				if (upd_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		we        = 1'b0;
		waddr     = seg_s1;
		wdata     = new_seg;
		load_out  = 1'b0;
		rd_addr   = iss_q[SEG_AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = iss_q[SEG_AW-1:0];
				wdata = (iss_q == '0) ? SEG_W'(1) : '0;
			end
			S_IDLE:   req.ready = 1'b1;
			S_SCAN:   rd_en = (iss_q != ISS_W'(NUM_SEGS)) && !scan_hit;
			S_UPDATE: begin
				rd_en = (iss_q <= {1'b0, hi_seg});
				we    = dv_s1;
			end
			S_DONE:   load_out = out_free;
			default: ;
		endcase
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (we) map_mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_s1 <= map_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rd_en) seg_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			dv_s1   <= 1'b0;
			iss_q   <= '0;
			free_q  <= FT_W'(BLK_TOTAL - 1);
		end else begin
			state_q <= state_d;
			dv_s1   <= rd_en;
			unique case (state_q)
				S_CLEAR: iss_q <= iss_q + ISS_W'(1);
				S_IDLE: begin
					if (req_xfer) begin
						iss_q <= (fn == FN_FREE || fn == FN_MARK) ?
							{1'b0, req_lo[BIDX_W-1 -: SEG_AW]} : '0;
					end
				end
				S_SCAN: begin
					if (rd_en) iss_q <= iss_q + ISS_W'(1);
					if (scan_hit) iss_q <= {1'b0, scan_first[BIDX_W-1 -: SEG_AW]};
				end
				S_UPDATE: begin
					if (rd_en) iss_q <= iss_q + ISS_W'(1);
					if (dv_s1) free_q <= set_q ? free_q - FT_W'(pc) : free_q + FT_W'(pc);
				end
				default: ;
			endcase
		end
	end

	// request registers and run tracking
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_xfer) begin
			cnt_q      <= cnt_eff;
			run_q      <= '0;
			lo_q       <= req_lo;
			hi_q       <= req_hi;
			set_q      <= (fn != FN_FREE);
			res_stat_q <= req_bad ? STAT_BAD : STAT_OK;
			res_idx_q  <= (fn == FN_MARK && !req_bad) ? req_lo : '0;
		end else if (state_q == S_SCAN && dv_s1) begin
			run_q <= run;
			if (scan_hit) begin
				lo_q      <= scan_first;
				hi_q      <= scan_end;
				res_idx_q <= scan_first;
			end else if (scan_last) begin
				res_stat_q <= STAT_NOSPACE;
				res_idx_q  <= '0;
			end
		end
	end

	// output register
	assign idx_x  = BX_W'(res_idx_q);
	assign free_x = FX_W'(free_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_stat_q <= res_stat_q;
			out_idx_q  <= idx_x[IDX_OUT_W-1:0];
			out_free_q <= free_x[FREE_W-1:0];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_stat_q;
	assign rsp.first_blk  = out_idx_q;
	assign rsp.free_count = out_free_q;

endmodule

// File: hw/rtl/bcba_checker.sv
// Port-level checker for the block allocator and its bind.
`include "assert_macros.svh"

module bcba_checker import bcba_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [STAT_W-1:0]    rsp_status,
	input logic [IDX_OUT_W-1:0] rsp_first_blk,
	input logic [FREE_W-1:0]    rsp_free_count
);

	logic [1:0] pend_q;
	logic       req_xfer, rsp_xfer, rsp_stall, rsp_fail;
	logic [STAT_W+IDX_OUT_W+FREE_W-1:0] rsp_bits;

	assign req_xfer  = req_valid && req_ready;
	assign rsp_xfer  = rsp_valid && rsp_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;
	assign rsp_fail  = rsp_valid && (rsp_status != STAT_OK);
	assign rsp_bits  = {rsp_status, rsp_first_blk, rsp_free_count};

	// track requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_xfer) - 2'(rsp_xfer);
		end
	end

	`BCBA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_bits))
	`BCBA_ASSERT(a_rsp_has_req, clk, arst_n, rsp_valid, pend_q != 2'd0)
	`BCBA_ASSERT(a_one_in_work, clk, arst_n, req_ready, pend_q <= 2'd1)
	`BCBA_ASSERT(a_idx_zero_on_fail, clk, arst_n, rsp_fail, rsp_first_blk == '0)

endmodule

bind bitmap_contiguous_block_allocator bcba_checker u_bcba_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_first_blk  (rsp.first_blk),
	.rsp_free_count (rsp.free_count)
);

// File: tb/tb_bitmap_contiguous_block_allocator.sv
// Self-checking testbench for the bitmap contiguous block allocator.
module tb_bitmap_contiguous_block_allocator;
	import bcba_pkg::*;

	localparam int NUM_BLK = BLK_TOTAL_DEF;

	typedef struct packed {
		stat_t                status;
		logic [IDX_OUT_W-1:0] first_blk;
		logic [FREE_W-1:0]    free_count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	bcba_req_if req_ch ();
	bcba_rsp_if rsp_ch ();

	bitmap_contiguous_block_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic     disk_used [NUM_BLK];
	int       disk_free;
	outcome_t outcome_q [$];

	int errors    = 0;
	int n_req     = 0;
	int n_rsp     = 0;
	int n_ok      = 0;
	int n_nospace = 0;
	int n_bad     = 0;
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int send_wait();
		if (send_calm)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic int take_wait();
		if (take_calm)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic outcome_t alloc_outcome(input func_t fn, input logic [START_W-1:0] st,
		input logic [CNT_W-1:0] cnt);
		outcome_t r;
		int run;
		int first;
		r.status    = STAT_OK;
		r.first_blk = '0;
		case (fn)
			FN_ALLOC_RUN: begin
				if (cnt == 0) begin
					r.status = STAT_BAD;
				end else begin
					run   = 0;
					first = -1;
					for (int i = 0; i < NUM_BLK; i++) begin
						if (first < 0) begin
							if (disk_used[i]) begin
								run = 0;
							end else begin
								run++;
								if (run == int'(cnt))
									first = i + 1 - int'(cnt);
							end
						end
					end
					if (first < 0) begin
						r.status = STAT_NOSPACE;
					end else begin
						for (int j = first; j < first + int'(cnt); j++)
							disk_used[j] = 1'b1;
						disk_free -= int'(cnt);
						r.first_blk = IDX_OUT_W'(first);
					end
				end
			end
			FN_FREE: begin
				if (cnt == 0 || int'(st) + int'(cnt) > NUM_BLK) begin
					r.status = STAT_BAD;
				end else begin
					for (int i = int'(st); i < int'(st) + int'(cnt); i++) begin
						if (disk_used[i]) begin
							disk_used[i] = 1'b0;
							disk_free++;
						end
					end
				end
			end
			FN_MARK: begin
				if (int'(st) >= NUM_BLK) begin
					r.status = STAT_BAD;
				end else begin
					if (!disk_used[st]) begin
						disk_used[st] = 1'b1;
						disk_free--;
					end
					r.first_blk = st;
				end
			end
			FN_ALLOC_ONE: begin
				first = -1;
				for (int i = 0; i < NUM_BLK; i++) begin
					if (first < 0 && !disk_used[i])
						first = i;
				end
				if (first < 0) begin
					r.status = STAT_NOSPACE;
				end else begin
					disk_used[first] = 1'b1;
					disk_free--;
					r.first_blk = IDX_OUT_W'(first);
				end
			end
		endcase
		r.free_count = disk_free[FREE_W-1:0];
		return r;
	endfunction

	task automatic send_req(input func_t fn, input logic [START_W-1:0] st,
		input logic [CNT_W-1:0] cnt);
		int gap;
		outcome_t o;
		gap = send_wait();
		if (gap > 0) begin
			@(negedge clk) req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid     <= 1'b1;
		req_ch.func      <= fn;
		req_ch.start_req <= st;
		req_ch.count     <= cnt;
		do @(posedge clk); while (!req_ch.ready);
		o = alloc_outcome(fn, st, cnt);
		outcome_q.push_back(o);
		n_req++;
		case (o.status)
			STAT_OK:      n_ok++;
			STAT_NOSPACE: n_nospace++;
			default:      n_bad++;
		endcase
	endtask

	task automatic test_corner_requests();
		send_req(FN_ALLOC_ONE, 9'd0, 10'd0);
		send_req(FN_ALLOC_RUN, 9'd0, 10'd0);
		send_req(FN_FREE, 9'd7, 10'd0);
		send_req(FN_FREE, 9'd511, 10'd2);
		send_req(FN_FREE, 9'd0, 10'd512);
		send_req(FN_ALLOC_RUN, 9'd0, 10'd513);
		send_req(FN_ALLOC_RUN, 9'd511, 10'd1023);
		send_req(FN_ALLOC_RUN, 9'd0, 10'd512);
		send_req(FN_ALLOC_ONE, 9'd511, 10'd1023);
		send_req(FN_ALLOC_RUN, 9'd0, 10'd1);
		send_req(FN_FREE, 9'd511, 10'd1);
		send_req(FN_FREE, 9'd511, 10'd1);
		send_req(FN_MARK, 9'd511, 10'd0);
		send_req(FN_MARK, 9'd511, 10'd1023);
		send_req(FN_FREE, 9'd0, 10'd512);
		send_req(FN_MARK, 9'd0, 10'd0);
	endtask

	task automatic test_fill_and_reclaim();
		send_req(FN_ALLOC_RUN, 9'd0, 10'd256);
		send_req(FN_ALLOC_RUN, 9'd0, 10'd255);
		send_req(FN_FREE, 9'd300, 10'd8);
		send_req(FN_ALLOC_RUN, 9'd0, 10'd9);
		send_req(FN_ALLOC_RUN, 9'd0, 10'd8);
		send_req(FN_FREE, 9'd0, 10'd1);
		send_req(FN_ALLOC_ONE, 9'd0, 10'd0);
		send_req(FN_FREE, 9'd0, 10'd512);
	endtask

	task automatic test_random_traffic();
		int pick;
		int lim;
		logic [START_W-1:0] st;
		logic [CNT_W-1:0] cnt;
		for (int k = 0; k < 1400; k++) begin
			if (k % 150 == 0) begin
				send_calm = ($urandom_range(0, 3) == 0);
				take_calm = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			st   = START_W'($urandom_range(0, NUM_BLK - 1));
			cnt  = CNT_W'($urandom_range(0, 1023));
			if (pick < 35) begin
				if ($urandom_range(0, 9) != 0)
					cnt = CNT_W'($urandom_range(1, 24));
				send_req(FN_ALLOC_RUN, st, cnt);
			end else if (pick < 56) begin
				lim = NUM_BLK - int'(st);
				if ($urandom_range(0, 7) != 0)
					cnt = CNT_W'($urandom_range(1, lim < 32 ? lim : 32));
				send_req(FN_FREE, st, cnt);
			end else if (pick < 70) begin
				send_req(FN_MARK, st, cnt);
			end else if (pick < 96) begin
				send_req(FN_ALLOC_ONE, st, cnt);
			end else begin
				send_req(FN_FREE, 9'd0, 10'd512);
			end
		end
		send_calm = 1'b0;
		take_calm = 1'b0;
	endtask

	initial begin
		outcome_t want;
		int n;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk) rsp_ch.ready <= 1'b1;
		forever begin
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
			n_rsp++;
			if (outcome_q.size() == 0) begin
				$display("%0t: response transfer with none pending: status %0d index %0d free %0d",
					$time, rsp_ch.status, rsp_ch.first_blk, rsp_ch.free_count);
				errors++;
			end else begin
				want = outcome_q.pop_front();
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status,
						rsp_ch.status);
					errors++;
				end
				if (rsp_ch.first_blk !== want.first_blk) begin
					$display("%0t: first_blk expected %0d got %0d", $time,
						want.first_blk, rsp_ch.first_blk);
					errors++;
				end
				if (rsp_ch.free_count !== want.free_count) begin
					$display("%0t: free_count expected %0d got %0d", $time,
						want.free_count, rsp_ch.free_count);
					errors++;
				end
			end
			n = take_wait();
			if (n > 0) begin
				@(negedge clk) rsp_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
				@(negedge clk) rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.func      = FN_ALLOC_RUN;
		req_ch.start_req = '0;
		req_ch.count     = '0;
		foreach (disk_used[i])
			disk_used[i] = 1'b0;
		disk_used[0] = 1'b1;
		disk_free    = NUM_BLK - 1;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_corner_requests();
		test_fill_and_reclaim();
		test_random_traffic();

		@(negedge clk) req_ch.valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d requests and checked %0d responses.", n_req, n_rsp);
		$display("Outcomes: %0d ok, %0d no space, %0d bad range or count.",
			n_ok, n_nospace, n_bad);
		if (errors == 0 && outcome_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
